[design/assert_macros.svh]
// assertion macros shared by the text console design
// no dependencies; taken in by the modules that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold at every clock edge outside reset
`define TCW_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// condition that, when seen, must lead to a consequence in the next cycle
`define TCW_ASSERT_NEXT(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (cond) |=> (conseq)) else $error(msg);

`endif

[design/tcw_pkg.sv]
// shared types, field widths and codes for the text console writer
// no dependencies; imported by every module of the block but tcw_ram
`timescale 1ns / 1ps

package tcw_pkg;

   // field widths of the item and result ports
   localparam int MODE_W      = 2;
   localparam int CHAR_W      = 8;
   localparam int ATTR_W      = 8;
   localparam int ROW_FIELD_W = 5;
   localparam int COL_FIELD_W = 7;
   localparam int CELL_W      = CHAR_W + ATTR_W;

   // default geometry and queue size
   localparam int DEFAULT_COLS        = 80;
   localparam int DEFAULT_ROWS        = 25;
   localparam int DEFAULT_QUEUE_DEPTH = 2;

   // item modes
   localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

   localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
   localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0F;

   // operations after classification
   localparam int OP_W = 3;
   localparam logic [OP_W-1:0] OP_NOP     = 3'd0;
   localparam logic [OP_W-1:0] OP_CHAR    = 3'd1;
   localparam logic [OP_W-1:0] OP_NEWLINE = 3'd2;
   localparam logic [OP_W-1:0] OP_READ    = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;

   // classified item as it travels through the queue
   typedef struct packed {
      logic [OP_W-1:0]        op;
      logic [CHAR_W-1:0]      char_code;
      logic [ROW_FIELD_W-1:0] read_row;
      logic [COL_FIELD_W-1:0] read_col;
   } cmd_type;

endpackage

[design/tcw_ram.sv]
// generic simple dual port ram with registered read data
// no dependencies; holds the screen cells of the text console
`timescale 1ns / 1ps

module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/tcw_front.sv]
// front end: takes request items and classifies them into operations
// depends on tcw_pkg; feeds the command queue
`timescale 1ns / 1ps

module tcw_front #(
   parameter int COLS = tcw_pkg::DEFAULT_COLS,
   parameter int ROWS = tcw_pkg::DEFAULT_ROWS
) (
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [tcw_pkg::MODE_W-1:0]       req_mode,
   input  logic [tcw_pkg::CHAR_W-1:0]       req_char_code,
   input  logic [tcw_pkg::ROW_FIELD_W-1:0]  req_read_row,
   input  logic [tcw_pkg::COL_FIELD_W-1:0]  req_read_col,
   input  logic                             queue_full,
   output logic                             push,
   output tcw_pkg::cmd_type                 push_cmd
);

   import tcw_pkg::*;

   logic read_in_range;

   // item is taken whenever the queue has room
   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

   assign read_in_range = (32'(req_read_row) < ROWS) && (32'(req_read_col) < COLS);

   // decode mode into an operation; out of range reads and the unused mode become no-ops
   always_comb begin
      push_cmd.char_code = req_char_code;
      push_cmd.read_row  = req_read_row;
      push_cmd.read_col  = req_read_col;
      case (req_mode)
         MODE_PUT:   push_cmd.op = (req_char_code == NEWLINE_CODE) ? OP_NEWLINE : OP_CHAR;
         MODE_READ:  push_cmd.op = read_in_range ? OP_READ : OP_NOP;
         MODE_CLEAR: push_cmd.op = OP_CLEAR;
         default:    push_cmd.op = OP_NOP;
      endcase
   end

endmodule

[design/tcw_queue.sv]
// short command queue between the front end and the back end
// depends on tcw_pkg and assert_macros.svh
`timescale 1ns / 1ps

module tcw_queue #(
   parameter int DEPTH = tcw_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tcw_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output tcw_pkg::cmd_type head_cmd
);

   import tcw_pkg::*;
   `include "assert_macros.svh"

   localparam int PW = $clog2(DEPTH);

   cmd_type         entries_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PW:0]     count_ff, count_in;

   assign full      = (count_ff == (PW+1)'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_cmd  = entries_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `TCW_ASSERT(a_queue_no_overflow, push |-> !full, "push into a full queue")
   `TCW_ASSERT(a_queue_no_underflow, pop |-> (count_ff != '0), "pop from an empty queue")
   `TCW_ASSERT_NEXT(a_queue_count_up, push && !pop, count_ff == $past(count_ff) + 1'b1, "count did not rise on push")

endmodule

[design/tcw_back.sv]
// back end: cursor, scroll offset, row valid bits and the screen ram sequencer
// depends on tcw_pkg, tcw_ram and assert_macros.svh
`timescale 1ns / 1ps

module tcw_back #(
   parameter int COLS = tcw_pkg::DEFAULT_COLS,
   parameter int ROWS = tcw_pkg::DEFAULT_ROWS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_not_empty,
   input  tcw_pkg::cmd_type                q_head,
   output logic                            q_pop,
   input  logic [tcw_pkg::ATTR_W-1:0]      text_attribute,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [tcw_pkg::CHAR_W-1:0]      rsp_cell_char,
   output logic [tcw_pkg::ATTR_W-1:0]      rsp_cell_attr,
   output logic [tcw_pkg::ROW_FIELD_W-1:0] rsp_cursor_row_out,
   output logic [tcw_pkg::COL_FIELD_W-1:0] rsp_cursor_col_out
);

   import tcw_pkg::*;
   `include "assert_macros.svh"

   localparam int RW = $clog2(ROWS);
   localparam int CW = $clog2(COLS + 1);
   localparam int DEPTH = ROWS * COLS;
   localparam int AW = $clog2(DEPTH);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EXEC  = 3'd1;
   localparam logic [2:0] S_SWEEP = 3'd2;
   localparam logic [2:0] S_READ  = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0]             state_ff, state_in;
   cmd_type                cmd_ff, cmd_in;
   logic [RW-1:0]          cursor_row_ff, cursor_row_in;
   logic [CW-1:0]          cursor_col_ff, cursor_col_in;
   logic [RW-1:0]          top_ff, top_in;
   logic [ROWS-1:0]        row_valid_ff, row_valid_in;
   logic [CW-1:0]          sweep_col_ff, sweep_col_in;
   logic [CHAR_W-1:0]      data_char_ff, data_char_in;
   logic [ATTR_W-1:0]      data_attr_ff, data_attr_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]      rsp_char_ff, rsp_char_in;
   logic [ATTR_W-1:0]      rsp_attr_ff, rsp_attr_in;
   logic [ROW_FIELD_W-1:0] rsp_row_ff, rsp_row_in;
   logic [COL_FIELD_W-1:0] rsp_col_ff, rsp_col_in;

   logic                   advance;
   logic [RW-1:0]          cur_phys;
   logic [RW-1:0]          read_phys;
   logic                   mem_wr_en;
   logic [AW-1:0]          mem_wr_addr;
   logic [CELL_W-1:0]      mem_wr_data;
   logic                   mem_rd_en;
   logic [AW-1:0]          mem_rd_addr;
   logic [CELL_W-1:0]      mem_rd_data;

   // screen row to ram row through the scroll offset
   function automatic logic [RW-1:0] phys_of(input logic [RW-1:0] lrow,
                                             input logic [RW-1:0] top);
      logic [RW:0] sum;
      sum = {1'b0, lrow} + {1'b0, top};
      if (sum >= (RW+1)'(ROWS)) begin
         sum = sum - (RW+1)'(ROWS);
      end
      return sum[RW-1:0];
   endfunction

   function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] prow,
                                             input logic [CW-1:0] col);
      return AW'(prow) * AW'(COLS) + AW'(col);
   endfunction

   assign cur_phys  = phys_of(cursor_row_ff, top_ff);
   assign read_phys = phys_of(RW'(cmd_ff.read_row), top_ff);

   // ram ports: sweep writes zeros, a put writes char and attribute
   assign mem_wr_addr = addr_of(cur_phys, (state_ff == S_SWEEP) ? sweep_col_ff : cursor_col_ff);
   assign mem_wr_data = (state_ff == S_SWEEP) ? '0 : {text_attribute, cmd_ff.char_code};
   assign mem_rd_addr = addr_of(read_phys, CW'(cmd_ff.read_col));

   tcw_ram #(
      .WIDTH(CELL_W),
      .DEPTH(DEPTH)
   ) u_screen_ram (
      .clock  (clock),
      .wr_en  (mem_wr_en),
      .wr_addr(mem_wr_addr),
      .wr_data(mem_wr_data),
      .rd_en  (mem_rd_en),
      .rd_addr(mem_rd_addr),
      .rd_data(mem_rd_data)
   );

   // item sequencer
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      cursor_row_in = cursor_row_ff;
      cursor_col_in = cursor_col_ff;
      top_in        = top_ff;
      row_valid_in  = row_valid_ff;
      sweep_col_in  = sweep_col_ff;
      data_char_in  = data_char_ff;
      data_attr_in  = data_attr_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_char_in   = rsp_char_ff;
      rsp_attr_in   = rsp_attr_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      advance       = 1'b0;
      q_pop         = 1'b0;
      mem_wr_en     = 1'b0;
      mem_rd_en     = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (q_not_empty) begin
               q_pop    = 1'b1;
               cmd_in   = q_head;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            data_char_in = '0;
            data_attr_in = '0;
            case (cmd_ff.op)
               OP_CHAR: begin
                  if (cursor_col_ff == CW'(COLS)) begin
                     // full row wraps first, then retries the put
                     advance = 1'b1;
                  end else if (!row_valid_ff[cur_phys]) begin
                     sweep_col_in = '0;
                     state_in     = S_SWEEP;
                  end else begin
                     mem_wr_en     = 1'b1;
                     cursor_col_in = cursor_col_ff + 1'b1;
                     state_in      = S_DONE;
                  end
               end
               OP_NEWLINE: begin
                  advance  = 1'b1;
                  state_in = S_DONE;
               end
               OP_READ: begin
                  if (row_valid_ff[read_phys]) begin
                     mem_rd_en = 1'b1;
                     state_in  = S_READ;
                  end else begin
                     state_in = S_DONE;
                  end
               end
               OP_CLEAR: begin
                  row_valid_in = '0;
                  state_in     = S_DONE;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_SWEEP: begin
            // zero a row not written since the last scroll or clear
            mem_wr_en = 1'b1;
            if (sweep_col_ff == CW'(COLS - 1)) begin
               row_valid_in[cur_phys] = 1'b1;
               state_in               = S_EXEC;
            end else begin
               sweep_col_in = sweep_col_ff + 1'b1;
            end
         end
         S_READ: begin
            data_char_in = mem_rd_data[CHAR_W-1:0];
            data_attr_in = mem_rd_data[CELL_W-1:CHAR_W];
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = data_char_ff;
               rsp_attr_in  = data_attr_ff;
               rsp_row_in   = ROW_FIELD_W'(cursor_row_ff);
               rsp_col_in   = COL_FIELD_W'(cursor_col_ff);
               if (q_not_empty) begin
                  q_pop    = 1'b1;
                  cmd_in   = q_head;
                  state_in = S_EXEC;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // move to the next row, scrolling on the last one
      if (advance) begin
         if (cursor_row_ff != RW'(ROWS - 1)) begin
            cursor_row_in = cursor_row_ff + 1'b1;
         end else begin
            top_in               = (top_ff == RW'(ROWS - 1)) ? '0 : top_ff + 1'b1;
            row_valid_in[top_ff] = 1'b0;
         end
         cursor_col_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cursor_row_ff <= '0;
         cursor_col_ff <= '0;
         top_ff        <= '0;
         row_valid_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cursor_row_ff <= cursor_row_in;
         cursor_col_ff <= cursor_col_in;
         top_ff        <= top_in;
         row_valid_ff  <= row_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      sweep_col_ff <= sweep_col_in;
      data_char_ff <= data_char_in;
      data_attr_ff <= data_attr_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_attr_ff  <= rsp_attr_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_cell_char      = rsp_char_ff;
   assign rsp_cell_attr      = rsp_attr_ff;
   assign rsp_cursor_row_out = rsp_row_ff;
   assign rsp_cursor_col_out = rsp_col_ff;

   `TCW_ASSERT(a_sweep_on_invalid_row, (state_ff == S_SWEEP) |-> !row_valid_ff[cur_phys], "sweep on a row already valid")
   `TCW_ASSERT(a_cursor_in_range, (32'(cursor_row_ff) < ROWS) && (32'(cursor_col_ff) <= COLS), "cursor out of range")
   `TCW_ASSERT_NEXT(a_put_advances, (state_ff == S_EXEC) && mem_wr_en, 32'(cursor_col_ff) == 32'($past(cursor_col_ff)) + 1, "put did not advance the cursor")

endmodule

[design/text_console_writer.sv]
// top level of the text console writer: attribute register, front, queue, back
// depends on tcw_pkg, tcw_front, tcw_queue, tcw_back
//
//   port group   direction   handshake             contents
//   req_*        in          req_valid/req_ready   mode, char code, read row and column
//   rsp_*        out         rsp_valid/rsp_ready   cell char and attribute, cursor after item
//   csr_*        in          csr_wr_en             text attribute byte
//
// one result per item; newline, clear, unused mode and out of range reads pass through the
// exec and done states in the back end, as does a put; a read adds the registered ram read
// a put on a full row first wraps to the next row in exec, then the write follows
// a put into a row not written since the last scroll or clear first zeroes the row in sweep
// reset clears the per-row valid bits at once, so no clearing pass runs after reset
// the queue keeps taking items while a result waits on rsp_ready, until it is full
`timescale 1ns / 1ps

module text_console_writer #(
   parameter int COLS        = tcw_pkg::DEFAULT_COLS,
   parameter int ROWS        = tcw_pkg::DEFAULT_ROWS,
   parameter int QUEUE_DEPTH = tcw_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [tcw_pkg::MODE_W-1:0]      req_mode,
   input  logic [tcw_pkg::CHAR_W-1:0]      req_char_code,
   input  logic [tcw_pkg::ROW_FIELD_W-1:0] req_read_row,
   input  logic [tcw_pkg::COL_FIELD_W-1:0] req_read_col,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [tcw_pkg::CHAR_W-1:0]      rsp_cell_char,
   output logic [tcw_pkg::ATTR_W-1:0]      rsp_cell_attr,
   output logic [tcw_pkg::ROW_FIELD_W-1:0] rsp_cursor_row_out,
   output logic [tcw_pkg::COL_FIELD_W-1:0] rsp_cursor_col_out,
   input  logic                            csr_wr_en,
   input  logic [tcw_pkg::ATTR_W-1:0]      csr_wr_data
);

   import tcw_pkg::*;

   logic [ATTR_W-1:0] text_attribute_ff, text_attribute_in;
   logic              queue_full;
   logic              push;
   cmd_type           push_cmd;
   logic              q_not_empty;
   cmd_type           q_head;
   logic              q_pop;

   // attribute register
   assign text_attribute_in = csr_wr_en ? csr_wr_data : text_attribute_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         text_attribute_ff <= ATTR_RESET;
      end else begin
         text_attribute_ff <= text_attribute_in;
      end
   end

   tcw_front #(
      .COLS(COLS),
      .ROWS(ROWS)
   ) u_front (
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_mode     (req_mode),
      .req_char_code(req_char_code),
      .req_read_row (req_read_row),
      .req_read_col (req_read_col),
      .queue_full   (queue_full),
      .push         (push),
      .push_cmd     (push_cmd)
   );

   tcw_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (q_pop),
      .not_empty(q_not_empty),
      .head_cmd (q_head)
   );

   tcw_back #(
      .COLS(COLS),
      .ROWS(ROWS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_not_empty       (q_not_empty),
      .q_head            (q_head),
      .q_pop             (q_pop),
      .text_attribute    (text_attribute_ff),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_cell_char     (rsp_cell_char),
      .rsp_cell_attr     (rsp_cell_attr),
      .rsp_cursor_row_out(rsp_cursor_row_out),
      .rsp_cursor_col_out(rsp_cursor_col_out)
   );

endmodule

[tb/sv/tb_text_console_writer.sv]
// self-checking testbench for text_console_writer: directed edge items, then
// row wrap, scrolling and mixed console traffic under random sender and receiver idling
// depends on tcw_pkg and text_console_writer
`timescale 1ns / 1ps

module tb_text_console_writer;
   import tcw_pkg::*;

   localparam int SCREEN_COLS = DEFAULT_COLS;
   localparam int SCREEN_ROWS = DEFAULT_ROWS;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   // one expected result: cell contents and cursor after the item
   typedef struct packed {
      logic [CHAR_W-1:0]      cell_char;
      logic [ATTR_W-1:0]      cell_attr;
      logic [ROW_FIELD_W-1:0] cursor_row;
      logic [COL_FIELD_W-1:0] cursor_col;
   } console_reply_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [MODE_W-1:0]      req_mode;
   logic [CHAR_W-1:0]      req_char_code;
   logic [ROW_FIELD_W-1:0] req_read_row;
   logic [COL_FIELD_W-1:0] req_read_col;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [CHAR_W-1:0]      rsp_cell_char;
   logic [ATTR_W-1:0]      rsp_cell_attr;
   logic [ROW_FIELD_W-1:0] rsp_cursor_row_out;
   logic [COL_FIELD_W-1:0] rsp_cursor_col_out;
   logic                   csr_wr_en;
   logic [ATTR_W-1:0]      csr_wr_data;

   // shadow copy of the console state
   logic [CELL_W-1:0] shadow_screen [SCREEN_ROWS][SCREEN_COLS];
   int                shadow_row;
   int                shadow_col;
   logic [ATTR_W-1:0] shadow_attr;

   console_reply_type console_replies[$];
   int                error_count = 0;
   int                items_sent = 0;
   int                burst_left = 0;
   int                ready_profile = 0;
   int                profile_left = 0;

   text_console_writer #(
      .COLS(SCREEN_COLS),
      .ROWS(SCREEN_ROWS)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_char_code      (req_char_code),
      .req_read_row       (req_read_row),
      .req_read_col       (req_read_col),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_cell_char      (rsp_cell_char),
      .rsp_cell_attr      (rsp_cell_attr),
      .rsp_cursor_row_out (rsp_cursor_row_out),
      .rsp_cursor_col_out (rsp_cursor_col_out),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // console behavior
   function automatic void wipe_screen();
      for (int r = 0; r < SCREEN_ROWS; r++)
         for (int c = 0; c < SCREEN_COLS; c++)
            shadow_screen[r][c] = '0;
   endfunction

   // move to column 0 of the next row, scrolling up on the last row
   function automatic void advance_row();
      if (shadow_row < SCREEN_ROWS - 1) begin
         shadow_row++;
      end else begin
         for (int r = 0; r < SCREEN_ROWS - 1; r++)
            for (int c = 0; c < SCREEN_COLS; c++)
               shadow_screen[r][c] = shadow_screen[r + 1][c];
         for (int c = 0; c < SCREEN_COLS; c++)
            shadow_screen[SCREEN_ROWS - 1][c] = '0;
      end
      shadow_col = 0;
   endfunction

   function automatic console_reply_type apply_console_item(
      logic [MODE_W-1:0] mode, logic [CHAR_W-1:0] code,
      logic [ROW_FIELD_W-1:0] row, logic [COL_FIELD_W-1:0] col);
      console_reply_type reply;
      reply = '0;
      case (mode)
         MODE_PUT: begin
            if (code == NEWLINE_CODE) begin
               advance_row();
            end else begin
               // a full row wraps before the character lands
               if (shadow_col >= SCREEN_COLS)
                  advance_row();
               shadow_screen[shadow_row][shadow_col] = {shadow_attr, code};
               shadow_col++;
            end
         end
         MODE_READ: begin
            if (row < SCREEN_ROWS && col < SCREEN_COLS) begin
               reply.cell_char = shadow_screen[row][col][CHAR_W-1:0];
               reply.cell_attr = shadow_screen[row][col][CELL_W-1:CHAR_W];
            end
         end
         MODE_CLEAR: wipe_screen();
         default: ;
      endcase
      reply.cursor_row = shadow_row[ROW_FIELD_W-1:0];
      reply.cursor_col = shadow_col[COL_FIELD_W-1:0];
      return reply;
   endfunction

   function automatic logic [CHAR_W-1:0] printable_code();
      logic [CHAR_W-1:0] code;
      do code = CHAR_W'($urandom_range(0, 255)); while (code == NEWLINE_CODE);
      return code;
   endfunction

   // send one item, idling between bursts
   task automatic push_item(logic [MODE_W-1:0] mode, logic [CHAR_W-1:0] code,
                            logic [ROW_FIELD_W-1:0] row, logic [COL_FIELD_W-1:0] col);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = $urandom_range(1, 6);
         burst_left = $urandom_range(1, 48);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_mode      <= mode;
      req_char_code <= code;
      req_read_row  <= row;
      req_read_col  <= col;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      console_replies.push_back(apply_console_item(mode, code, row, col));
      if (mode != MODE_UNUSED)
         items_sent++;
   endtask

   task automatic put_char(logic [CHAR_W-1:0] code);
      push_item(MODE_PUT, code, ROW_FIELD_W'($urandom), COL_FIELD_W'($urandom));
   endtask

   task automatic read_cell(int row, int col);
      push_item(MODE_READ, CHAR_W'($urandom), ROW_FIELD_W'(row), COL_FIELD_W'(col));
   endtask

   // stop sending and wait for every outstanding result
   task automatic drain_items();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (console_replies.size() != 0) @(posedge clock);
   endtask

   task automatic set_text_attribute(logic [ATTR_W-1:0] value);
      drain_items();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      shadow_attr = value;
   endtask

   // field extremes, unused mode, out of range reads, clear
   task automatic test_field_extremes();
      read_cell(0, 0);
      read_cell(31, 127);
      read_cell(SCREEN_ROWS, 0);
      read_cell(SCREEN_ROWS - 1, SCREEN_COLS);
      read_cell(SCREEN_ROWS - 1, SCREEN_COLS - 1);
      push_item(MODE_UNUSED, 8'hFF, 5'd31, 7'd127);
      push_item(MODE_UNUSED, 8'h00, 5'd0, 7'd0);
      push_item(MODE_PUT, 8'h00, 5'd31, 7'd127);
      push_item(MODE_PUT, 8'hFF, 5'd0, 7'd0);
      put_char(NEWLINE_CODE);
      put_char(8'hF5);
      put_char(8'h0B);
      read_cell(0, 0);
      read_cell(0, 1);
      read_cell(1, 0);
      read_cell(1, 1);
      push_item(MODE_CLEAR, 8'hFF, 5'd31, 7'd127);
      read_cell(0, 0);
      read_cell(1, 0);
      put_char(NEWLINE_CODE);
   endtask

   // full rows wrap mid screen, then scroll at the bottom
   task automatic test_row_wrap_and_scroll();
      repeat (SCREEN_COLS) put_char(printable_code());
      read_cell(shadow_row, SCREEN_COLS - 1);
      put_char(printable_code());
      read_cell(shadow_row, 0);
      repeat (SCREEN_ROWS) put_char(NEWLINE_CODE);
      repeat (3) begin
         repeat (SCREEN_COLS) put_char(printable_code());
         read_cell(SCREEN_ROWS - 1, SCREEN_COLS - 1);
         read_cell(SCREEN_ROWS - 2, 0);
      end
      // newline on a full bottom row
      put_char(NEWLINE_CODE);
      read_cell(SCREEN_ROWS - 2, SCREEN_COLS - 1);
   endtask

   // lines of random text with reads, newlines, clears and noise
   task automatic test_mixed_traffic(int count);
      int target;
      int pick;
      int len;
      int row;
      target = items_sent + count;
      while (items_sent < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            case ($urandom_range(0, 3))
               0:       len = SCREEN_COLS;
               1:       len = SCREEN_COLS + $urandom_range(1, 20);
               default: len = $urandom_range(0, 30);
            endcase
            repeat (len) put_char(printable_code());
            if ($urandom_range(0, 9) < 7)
               put_char(NEWLINE_CODE);
         end else if (pick < 85) begin
            repeat ($urandom_range(1, 4)) begin
               case ($urandom_range(0, 9))
                  0: read_cell($urandom_range(0, 31), $urandom_range(0, 127));
                  1, 2, 3: read_cell($urandom_range(0, SCREEN_ROWS - 1),
                                     $urandom_range(0, SCREEN_COLS - 1));
                  default: begin
                     row = shadow_row;
                     if (row > 0 && $urandom_range(0, 1))
                        row--;
                     read_cell(row, $urandom_range(0, SCREEN_COLS - 1));
                  end
               endcase
            end
         end else if (pick < 91) begin
            repeat ($urandom_range(1, 30)) put_char(NEWLINE_CODE);
         end else if (pick < 94) begin
            push_item(MODE_UNUSED, CHAR_W'($urandom), ROW_FIELD_W'($urandom),
                      COL_FIELD_W'($urandom));
         end else if (pick < 96) begin
            push_item(MODE_CLEAR, CHAR_W'($urandom), ROW_FIELD_W'($urandom),
                      COL_FIELD_W'($urandom));
         end else begin
            put_char(CHAR_W'($urandom));
         end
      end
   endtask

   // receiver stalls: full rate, light stalls or heavy stalls, chosen at random
   always @(negedge clock) begin
      if (profile_left == 0) begin
         ready_profile <= $urandom_range(0, 2);
         profile_left  <= $urandom_range(16, 96);
      end else begin
         profile_left <= profile_left - 1;
      end
      case (ready_profile)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= ($urandom_range(0, 3) != 0);
         default: rsp_ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endfunction

   // compare each result with the oldest expectation
   always @(posedge clock) begin : check_results
      console_reply_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (console_replies.size() == 0) begin
            $error("result with no item outstanding");
            error_count++;
         end else begin
            want = console_replies.pop_front();
            check_field("cell_char", want.cell_char, rsp_cell_char);
            check_field("cell_attr", want.cell_attr, rsp_cell_attr);
            check_field("cursor_row_out", 8'(want.cursor_row), 8'(rsp_cursor_row_out));
            check_field("cursor_col_out", 8'(want.cursor_col), 8'(rsp_cursor_col_out));
         end
      end
   end

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_mode      = MODE_PUT;
      req_char_code = '0;
      req_read_row  = '0;
      req_read_col  = '0;
      rsp_ready     = 1'b0;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      wipe_screen();
      shadow_row  = 0;
      shadow_col  = 0;
      shadow_attr = ATTR_RESET;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_field_extremes();
      set_text_attribute(8'h00);
      test_row_wrap_and_scroll();
      set_text_attribute(8'hFF);
      test_mixed_traffic(300);
      set_text_attribute(ATTR_W'($urandom));
      test_mixed_traffic(300);
      set_text_attribute(ATTR_W'($urandom));
      test_mixed_traffic(300);

      drain_items();
      repeat (4 * SCREEN_COLS) @(posedge clock);
      if (error_count == 0)
         $display("tb_text_console_writer: done, clean");
      else
         $display("tb_text_console_writer: done, errors");
      $finish;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("tb_text_console_writer: done, errors");
      $finish;
   end

endmodule

[sim.f]
+incdir+design
design/tcw_pkg.sv
design/tcw_ram.sv
design/tcw_front.sv
design/tcw_queue.sv
design/tcw_back.sv
design/text_console_writer.sv
tb/sv/tb_text_console_writer.sv
